>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the allocator controller rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define CPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// types and constants of the contiguous page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

  // bitmap word geometry
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORD_AW = 6;

  // field widths
  localparam int unsigned RUN_W    = 14;
  localparam int unsigned FIRST_W  = 13;
  localparam int unsigned START_W  = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned IDX_W    = 16;  // widest page index over the PAGES range
  localparam int unsigned CNT_W    = 15;  // run counts and page sums

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD   = 2'd2;

  localparam logic CFG_PAGES_IN_USE = 1'b0;
  localparam logic CFG_REGION_BASE  = 1'b1;

  localparam logic [RUN_W-1:0] PAGES_IN_USE_RST = 14'd8192;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } cpa_state_e;

  // outcome of evaluating one bitmap word
  typedef struct packed {
    logic               found;
    logic [WORD_AW-1:0] hit_bit;
    logic [CNT_W-1:0]   carry;
  } fnd_t;

  // finished request handed to the output stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    start;
    logic                has_addr;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/cpa_run_finder.sv
// ----------------------------------------------------------------------------
// cpa_run_finder
// evaluates one 64-page bitmap word against the run being searched
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_run_finder import cpa_pkg::*; (
  input  wire logic [WORD_W-1:0]  word_i,
  input  wire logic               last_word_i,
  input  wire logic [WORD_AW-1:0] limit_lo_i,
  input  wire logic [CNT_W-1:0]   run_i,
  input  wire logic [CNT_W-1:0]   len_i,
  output fnd_t                    fnd_o
);

  logic [WORD_W-1:0] used;
  logic [WORD_W-1:0] hit;

  // pages at or above the limit count as used
  always_comb begin
    if (last_word_i && (limit_lo_i != '0)) begin
      used = word_i | ({WORD_W{1'b1}} << limit_lo_i);
    end else begin
      used = word_i;
    end
  end

  always_comb begin
    logic [WORD_W-1:0]  hv;
    logic [WORD_W-1:0]  nv;
    logic [WORD_AW-1:0] hp [WORD_W];
    logic [WORD_AW-1:0] np [WORD_W];
    logic [CNT_W-1:0]   run_b [WORD_W];
    hv = used;
    for (int i = 0; i < WORD_W; i++) begin
      hp[i] = WORD_AW'(i);
    end
    // prefix scan: highest used position at or below each bit
    for (int l = 0; l < WORD_AW; l++) begin
      nv = hv;
      np = hp;
      for (int i = (1 << l); i < WORD_W; i++) begin
        if (!hv[i] && hv[i - (1 << l)]) begin
          nv[i] = 1'b1;
          np[i] = hp[i - (1 << l)];
        end
      end
      hv = nv;
      hp = np;
    end
    for (int i = 0; i < WORD_W; i++) begin
      if (hv[i]) begin
        run_b[i] = CNT_W'(i) - CNT_W'(hp[i]);
      end else begin
        run_b[i] = run_i + CNT_W'(i + 1);
      end
      hit[i] = (run_b[i] >= len_i);
    end
    fnd_o.carry   = run_b[WORD_W-1];
    fnd_o.found   = |hit;
    fnd_o.hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        fnd_o.hit_bit = WORD_AW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// page bitmap memory with its scan and read-modify-write sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cpa_ctrl import cpa_pkg::*; #(
  parameter int unsigned PAGES = 8192
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [RUN_W-1:0]   run_pages_i,
  input  wire logic [FIRST_W-1:0] first_page_i,
  input  wire logic [CNT_W-1:0]   limit_i,
  output logic                    res_valid_o,
  output res_t                    res_o,
  input  wire logic               res_take_i
);

  localparam int unsigned WORDS = (PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned GW    = WA_W + WORD_AW;

  cpa_state_e state_q, state_d;

  logic [WA_W-1:0]     clr_q, clr_d;
  logic [WA_W-1:0]     nxt_q, nxt_d;
  logic                rd_done_q, rd_done_d;
  logic                pend_q;
  logic [WA_W-1:0]     wcur_q;
  logic                kind_q, kind_d;
  logic [RUN_W-1:0]    len_q, len_d;
  logic [CNT_W-1:0]    run_q, run_d;
  logic [GW-1:0]       lo_q, lo_d;
  logic [GW-1:0]       hi_q, hi_d;
  logic [GW-1:0]       start_q, start_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic              ram_we;
  logic [WA_W-1:0]   ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WA_W-1:0]   ram_raddr;

  logic [CNT_W-1:0]   lm1;
  logic [WA_W-1:0]    last_w;
  logic [WA_W-1:0]    lo_w;
  logic [WA_W-1:0]    hi_w;
  logic [WORD_AW-1:0] lo_b;
  logic [WORD_AW-1:0] hi_b;
  logic [WORD_W-1:0]  mask;
  logic [CNT_W-1:0]   free_end;
  logic [GW-1:0]      hit_idx;
  logic [GW-1:0]      hit_start;
  fnd_t               fnd;

  assign lm1    = limit_i - CNT_W'(1);
  assign last_w = WA_W'(lm1 >> WORD_AW);
  assign lo_w   = lo_q[GW-1:WORD_AW];
  assign hi_w   = hi_q[GW-1:WORD_AW];

  // edge masks of the run within the word now being written
  assign lo_b = (wcur_q == lo_w) ? lo_q[WORD_AW-1:0] : '0;
  assign hi_b = (wcur_q == hi_w) ? hi_q[WORD_AW-1:0] : '1;
  assign mask = ({WORD_W{1'b1}} << lo_b) &
                ({WORD_W{1'b1}} >> (WORD_AW'(WORD_W - 1) - hi_b));

  assign free_end  = CNT_W'(first_page_i) + CNT_W'(run_pages_i);
  assign hit_idx   = {wcur_q, fnd.hit_bit};
  assign hit_start = hit_idx + GW'(1) - GW'(len_q);

  cpa_run_finder u_finder (
    .word_i      (rdata_q),
    .last_word_i (wcur_q == last_w),
    .limit_lo_i  (limit_i[WORD_AW-1:0]),
    .run_i       (run_q),
    .len_i       (CNT_W'(len_q)),
    .fnd_o       (fnd)
  );

  // bitmap memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      mem[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      rdata_q <= mem[ram_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      nxt_q     <= '0;
      rd_done_q <= 1'b0;
      pend_q    <= 1'b0;
      kind_q    <= KIND_ALLOC;
      status_q  <= STAT_OK;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      nxt_q     <= nxt_d;
      rd_done_q <= rd_done_d;
      pend_q    <= ram_re;
      kind_q    <= kind_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      wcur_q <= ram_raddr;
    end
    len_q   <= len_d;
    run_q   <= run_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    start_q <= start_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    nxt_d     = nxt_q;
    rd_done_d = rd_done_q;
    kind_d    = kind_q;
    len_d     = len_q;
    run_d     = run_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    start_d   = start_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = wcur_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = nxt_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == WA_W'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + WA_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d    = kind_i;
          len_d     = run_pages_i;
          run_d     = '0;
          nxt_d     = '0;
          rd_done_d = 1'b0;
          start_d   = '0;
          status_d  = STAT_OK;
          if (run_pages_i == '0) begin
            status_d = STAT_BAD;
            state_d  = ST_DONE;
          end else if (kind_i == KIND_ALLOC) begin
            if (limit_i == '0) begin
              status_d = STAT_NOFIT;
              state_d  = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end else if (free_end > limit_i) begin
            status_d = STAT_BAD;
            state_d  = ST_DONE;
          end else begin
            lo_d    = GW'(first_page_i);
            hi_d    = GW'(free_end - CNT_W'(1));
            nxt_d   = WA_W'(first_page_i >> WORD_AW);
            state_d = ST_MARK;
          end
        end
      end

      ST_SCAN: begin
        // reads run one word ahead of the evaluation
        ram_re = !rd_done_q && !(pend_q && fnd.found);
        if (ram_re) begin
          nxt_d = nxt_q + WA_W'(1);
          if (nxt_q == last_w) begin
            rd_done_d = 1'b1;
          end
        end
        if (pend_q) begin
          if (fnd.found) begin
            start_d   = hit_start;
            lo_d      = hit_start;
            hi_d      = hit_idx;
            nxt_d     = hit_start[GW-1:WORD_AW];
            rd_done_d = 1'b0;
            state_d   = ST_MARK;
          end else if (wcur_q == last_w) begin
            status_d = STAT_NOFIT;
            state_d  = ST_DONE;
          end else begin
            run_d = fnd.carry;
          end
        end
      end

      ST_MARK: begin
        ram_re = !rd_done_q;
        if (ram_re) begin
          nxt_d = nxt_q + WA_W'(1);
          if (nxt_q == hi_w) begin
            rd_done_d = 1'b1;
          end
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wcur_q;
          ram_wdata = (kind_q == KIND_FREE) ? (rdata_q & ~mask) : (rdata_q | mask);
          if (wcur_q == hi_w) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.status      = status_q;
  assign res_o.start       = IDX_W'(start_q);
  assign res_o.has_addr    = (kind_q == KIND_ALLOC) && (status_q == STAT_OK);

  `CPA_ASSERT(a_rw_apart, !(ram_we && ram_re && (ram_waddr == ram_raddr)), "read and write hit one word")
  `CPA_ASSERT(a_scan_bound, (state_q == ST_SCAN && pend_q) |-> (wcur_q <= last_w), "scan ran past the last word")
  `CPA_ASSERT(a_run_fits, (state_q == ST_DONE && kind_q == KIND_ALLOC && status_q == STAT_OK) |-> ((32'(hi_q) < 32'(limit_i)) && (32'(hi_q) + 32'd1 - 32'(start_q) == 32'(len_q))), "allocated run has wrong span")
  `CPA_ASSERT_NEXT(a_mark_drained, state_q == ST_MARK && pend_q && wcur_q == hi_w, !pend_q, "read issued past the run end")

endmodule

`default_nettype wire

>>> hdl/contiguous_page_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator_top
// first-fit allocator of contiguous page runs over a used/free page bitmap
// ----------------------------------------------------------------------------
// latency grows with words scanned and marked; bitmap scanned one 64-page word a cycle:
//   allocate scans until a run fits, then marks the words it covers; no fit ends with the scan
// free marks the words the run covers; zero length, zero page count or bad free skip both
// one item at a time; the next is taken while a result waits in the output register
// after reset a clearing pass writes ceil(PAGES/64) words, one a cycle, before items are taken
// config registers reset to pages_in_use 8192 and region_base 0
`default_nettype none

module contiguous_page_allocator_top import cpa_pkg::*; #(
  parameter int unsigned PAGES      = 8192,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                kind_i,
  input  wire logic [RUN_W-1:0]    run_pages_i,
  input  wire logic [FIRST_W-1:0]  first_page_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [START_W-1:0]       start_page_o,
  output logic [ADDR_W-1:0]        address_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [ADDR_W-1:0]   cfg_data_i
);

  logic [RUN_W-1:0]    pages_in_use_q;
  logic [ADDR_W-1:0]   region_base_q;
  logic [CNT_W-1:0]    limit;
  logic                res_valid;
  res_t                res;
  logic                res_take;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [START_W-1:0]  start_page_q;
  logic [ADDR_W-1:0]   address_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_in_use_q <= PAGES_IN_USE_RST;
      region_base_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_PAGES_IN_USE: pages_in_use_q <= cfg_data_i[RUN_W-1:0];
        CFG_REGION_BASE:  region_base_q  <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // page count clamped to the bitmap size
  always_comb begin
    if (32'(pages_in_use_q) > 32'(PAGES)) begin
      limit = CNT_W'(PAGES);
    end else begin
      limit = CNT_W'(pages_in_use_q);
    end
  end

  cpa_ctrl #(
    .PAGES (PAGES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .run_pages_i  (run_pages_i),
    .first_page_i (first_page_i),
    .limit_i      (limit),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take && res_valid) begin
      status_q     <= res.status;
      start_page_q <= START_W'(res.start);
      if (res.has_addr) begin
        address_q <= region_base_q + (ADDR_W'(res.start) << PAGE_SHIFT);
      end else begin
        address_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign start_page_o = start_page_q;
  assign address_o    = address_q;

endmodule

`default_nettype wire
